// File: hdl/pcbh_pkg.sv
// pcbh_pkg: shared types, constants and helper functions for the cell binning block
// used by pcbh_lane and periodic_cell_binning_with_halo_core
package pcbh_pkg;

    localparam int MaxDivisions = 16;
    localparam int PosBits      = 24;
    localparam int CellBits     = $clog2(MaxDivisions);
    localparam int NdBits       = CellBits + 1;
    localparam int AddrBits     = 3 * CellBits;
    localparam int NumCells     = MaxDivisions * MaxDivisions * MaxDivisions;
    localparam int CntBits      = 32;
    localparam int QBits        = CellBits + 1;
    localparam int CfgBits      = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_DIVISIONS   = 2'd0;
    localparam logic [1:0] CFG_CELL_LENGTH = 2'd1;
    localparam logic [1:0] CFG_BUFFER      = 2'd2;

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIV,
        L_CLAMP,
        L_OFF,
        L_FLAG
    } t_lane_st;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN,
        S_READ,
        S_MOD
    } t_core_st;

    // per-axis binning result
    typedef struct packed {
        logic [CellBits-1:0] home;
        logic                act;
        logic                plus;
    } t_lane_res;

    // axis mask of a copy kind: bit0 x, bit1 y, bit2 z
    function automatic logic [2:0] kind_axes(input logic [2:0] k);
        logic [2:0] a;
        unique case (k)
            3'd0: a = 3'b000;
            3'd1: a = 3'b001;
            3'd2: a = 3'b010;
            3'd3: a = 3'b100;
            3'd4: a = 3'b011;
            3'd5: a = 3'b101;
            3'd6: a = 3'b110;
            3'd7: a = 3'b111;
            default: a = 3'b000;
        endcase
        return a;
    endfunction

    function automatic logic kind_ok(input logic [2:0] k, input logic [2:0] active);
        return (kind_axes(k) & active) == kind_axes(k);
    endfunction

    // any enabled copy kind after k
    function automatic logic more_after(input logic [2:0] k, input logic [2:0] active);
        logic m;
        m = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (j > int'(k) && kind_ok(3'(j), active)) begin
                m = 1'b1;
            end
        end
        return m;
    endfunction

    // periodic step of a cell index
    function automatic logic [CellBits-1:0] wrap_step(input logic [CellBits-1:0] c,
                                                      input logic plus,
                                                      input logic [NdBits-1:0] nd);
        logic [NdBits-1:0] c1;
        logic [CellBits-1:0] r;
        c1 = {1'b0, c} + NdBits'(1);
        if (plus) begin
            r = (c1 >= nd) ? '0 : c1[CellBits-1:0];
        end else begin
            r = (c == '0) ? CellBits'(nd - NdBits'(1)) : c - CellBits'(1);
        end
        return r;
    endfunction

endpackage

// File: hdl/pcbh_lane.sv
// pcbh_lane: one axis of binning, shift-subtract quotient, clamp, offset and halo flag
// depends on pcbh_pkg
module pcbh_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pcbh_pkg::PosBits-1:0]     i_pos,
    input  logic [pcbh_pkg::CfgBits-1:0]     i_len,
    input  logic [pcbh_pkg::CfgBits-1:0]     i_buf,
    input  logic [pcbh_pkg::NdBits-1:0]      i_nd,
    output logic                             o_done,
    output pcbh_pkg::t_lane_res              o_res
);

    localparam int TrialBits = pcbh_pkg::PosBits + pcbh_pkg::QBits;

    pcbh_pkg::t_lane_st r_st, n_st;
    logic [pcbh_pkg::PosBits-1:0]      r_rem;
    logic [pcbh_pkg::QBits-1:0]        r_q;
    logic [$clog2(pcbh_pkg::QBits)-1:0] r_bit;
    logic [pcbh_pkg::CellBits-1:0]     r_cell;
    logic [pcbh_pkg::PosBits-1:0]      r_off;
    pcbh_pkg::t_lane_res               r_res;

    logic [TrialBits-1:0]              trial;
    logic                              fits;
    logic [pcbh_pkg::CellBits-1:0]     nd_m1;
    logic [pcbh_pkg::CellBits-1:0]     clamp_c;
    logic [pcbh_pkg::PosBits+pcbh_pkg::CellBits-1:0] prod;
    logic signed [pcbh_pkg::CfgBits+1:0] hi_lim;
    logic                              minus, plus;

    // one quotient bit per cycle, msb first
    assign trial = TrialBits'(i_len) << r_bit;
    assign fits  = TrialBits'(r_rem) >= trial;

    assign nd_m1   = pcbh_pkg::CellBits'(i_nd - pcbh_pkg::NdBits'(1));
    assign clamp_c = (r_q[pcbh_pkg::QBits-1] || r_q[pcbh_pkg::CellBits-1:0] > nd_m1)
                     ? nd_m1 : r_q[pcbh_pkg::CellBits-1:0];

    assign prod   = r_cell * i_len;
    assign hi_lim = $signed({2'b00, i_len}) - $signed({2'b00, i_buf});
    assign minus  = r_off < i_buf;
    assign plus   = $signed({2'b00, r_off}) > hi_lim;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pcbh_pkg::L_IDLE:  if (i_start) n_st = pcbh_pkg::L_DIV;
            pcbh_pkg::L_DIV:   if (r_bit == '0) n_st = pcbh_pkg::L_CLAMP;
            pcbh_pkg::L_CLAMP: n_st = pcbh_pkg::L_OFF;
            pcbh_pkg::L_OFF:   n_st = pcbh_pkg::L_FLAG;
            pcbh_pkg::L_FLAG:  n_st = pcbh_pkg::L_IDLE;
            default:           n_st = pcbh_pkg::L_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_st == pcbh_pkg::L_FLAG);
        o_res  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pcbh_pkg::L_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            pcbh_pkg::L_IDLE: begin
                r_rem <= i_pos;
                r_q   <= '0;
                r_bit <= ($clog2(pcbh_pkg::QBits))'(pcbh_pkg::QBits - 1);
            end
            pcbh_pkg::L_DIV: begin
                if (fits) begin
                    r_rem        <= r_rem - pcbh_pkg::PosBits'(trial);
                    r_q[r_bit]   <= 1'b1;
                end
                r_bit <= r_bit - 1'b1;
            end
            pcbh_pkg::L_CLAMP: r_cell <= clamp_c;
            pcbh_pkg::L_OFF:   r_off  <= i_pos - pcbh_pkg::PosBits'(prod);
            pcbh_pkg::L_FLAG: begin
                r_res.home <= r_cell;
                r_res.act  <= minus | plus;
                r_res.plus <= plus;
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/periodic_cell_binning_with_halo_core.sv
// periodic_cell_binning_with_halo_core: top level, three axis lanes, copy merger and cell counters
// depends on pcbh_pkg and pcbh_lane
//
// One particle beat is binned by three axis lanes working side by side (a start step, 5
// quotient steps, clamp, offset multiply and halo compare), then the merger walks the copy
// kinds up to the last enabled one, passing each skipped kind in the read state and taking
// each emitted copy through read and modify for the counter read-modify-write on the
// single-port 4096 x 32 count memory. A new particle beat is taken only in the idle state,
// after the last copy of the previous one; a stalled result beat holds the merger in modify.
// After reset a clearing pass zeroes all 4096 cells of the count memory; no particle is taken
// during it, configuration writes are.
module periodic_cell_binning_with_halo_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [23:0] i_pos_x,
    input  logic [23:0] i_pos_y,
    input  logic [23:0] i_pos_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_out_x,
    output logic [23:0] o_out_y,
    output logic [23:0] o_out_z,
    output logic [3:0]  o_cell_x,
    output logic [3:0]  o_cell_y,
    output logic [3:0]  o_cell_z,
    output logic [2:0]  o_copy_kind,
    output logic [31:0] o_cell_count,
    output logic [31:0] o_total_count,
    output logic        o_last_copy
);

    localparam int CB = pcbh_pkg::CellBits;

    pcbh_pkg::t_core_st r_st, n_st;

    logic [4:0]  r_div;
    logic [23:0] r_len;
    logic [23:0] r_buf;

    logic [23:0] r_px, r_py, r_pz;
    logic [2:0]  r_k;
    logic [pcbh_pkg::AddrBits-1:0] r_clr;
    logic [31:0] r_total;

    logic [pcbh_pkg::CntBits-1:0] r_mem [pcbh_pkg::NumCells];
    logic [pcbh_pkg::CntBits-1:0] r_rd;

    logic        r_out_valid;
    logic [23:0] r_ox, r_oy, r_oz;
    logic [CB-1:0] r_cx, r_cy, r_cz;
    logic [2:0]  r_okind;
    logic [31:0] r_ocnt, r_otot;
    logic        r_olast;

    logic [pcbh_pkg::NdBits-1:0] nd;
    logic [23:0] len_eff;
    logic        accept, lanes_done, ok_k, more, out_free, emit;
    logic [2:0]  active, axes;
    logic [2:0]  done_v;
    pcbh_pkg::t_lane_res res [3];
    logic [23:0] lane_pos [3];
    logic [CB-1:0] dst [3];
    logic [pcbh_pkg::AddrBits-1:0] addr;
    logic [31:0] cnt_inc, tot_inc;

    // effective configuration
    assign nd = (r_div < 5'd2) ? pcbh_pkg::NdBits'(2)
              : (r_div > 5'(pcbh_pkg::MaxDivisions)) ? pcbh_pkg::NdBits'(pcbh_pkg::MaxDivisions)
              : pcbh_pkg::NdBits'(r_div);
    assign len_eff = (r_len == '0) ? 24'd1 : r_len;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= 5'd2;
            r_len <= 24'd256;
            r_buf <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                pcbh_pkg::CFG_DIVISIONS:   r_div <= i_cfg_data[4:0];
                pcbh_pkg::CFG_CELL_LENGTH: r_len <= i_cfg_data;
                pcbh_pkg::CFG_BUFFER:      r_buf <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // axis lanes
    assign lane_pos[0] = r_px;
    assign lane_pos[1] = r_py;
    assign lane_pos[2] = r_pz;

    for (genvar a = 0; a < 3; a++) begin : g_lane
        pcbh_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_st == pcbh_pkg::S_BIN && r_k == 3'd0),
            .i_pos   (lane_pos[a]),
            .i_len   (len_eff),
            .i_buf   (r_buf),
            .i_nd    (nd),
            .o_done  (done_v[a]),
            .o_res   (res[a])
        );
        assign active[a] = res[a].act;
        assign dst[a] = (axes[a]) ? pcbh_pkg::wrap_step(res[a].home, res[a].plus, nd)
                                  : res[a].home;
    end

    assign lanes_done = &done_v;

    // copy selection
    assign axes     = pcbh_pkg::kind_axes(r_k);
    assign ok_k     = pcbh_pkg::kind_ok(r_k, active);
    assign more     = pcbh_pkg::more_after(r_k, active);
    assign addr     = {dst[0], dst[1], dst[2]};
    assign cnt_inc  = (r_rd == '1) ? r_rd : r_rd + 32'd1;
    assign tot_inc  = (r_total == '1) ? r_total : r_total + 32'd1;
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pcbh_pkg::S_CLEAR: if (r_clr == '1) n_st = pcbh_pkg::S_IDLE;
            pcbh_pkg::S_IDLE:  if (i_in_valid) n_st = pcbh_pkg::S_BIN;
            pcbh_pkg::S_BIN:   if (lanes_done) n_st = pcbh_pkg::S_READ;
            pcbh_pkg::S_READ:  if (ok_k) n_st = pcbh_pkg::S_MOD;
            pcbh_pkg::S_MOD:   if (out_free) n_st = more ? pcbh_pkg::S_READ : pcbh_pkg::S_IDLE;
            default:           n_st = pcbh_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready = (r_st == pcbh_pkg::S_IDLE);
        emit       = (r_st == pcbh_pkg::S_MOD) && out_free;
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= pcbh_pkg::S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == pcbh_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // kind counter: cleared on accept and held at zero while binning, which keeps the lane start asserted
            if (accept) begin
                r_k <= '0;
            end else if (r_st == pcbh_pkg::S_BIN) begin
                r_k <= '0;
            end else if (r_st == pcbh_pkg::S_READ && !ok_k) begin
                r_k <= r_k + 3'd1;
            end else if (emit) begin
                r_k <= r_k + 3'd1;
            end
            if (emit) begin
                r_total <= tot_inc;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // particle capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
        end
    end

    // count memory: clearing pass, read in read phase, write back on emit
    always_ff @(posedge i_clk) begin
        if (r_st == pcbh_pkg::S_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (emit) begin
            r_mem[addr] <= cnt_inc;
        end
        if (r_st == pcbh_pkg::S_READ) begin
            r_rd <= r_mem[addr];
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ox    <= r_px;
            r_oy    <= r_py;
            r_oz    <= r_pz;
            r_cx    <= dst[0];
            r_cy    <= dst[1];
            r_cz    <= dst[2];
            r_okind <= r_k;
            r_ocnt  <= cnt_inc;
            r_otot  <= tot_inc;
            r_olast <= !more;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_z       = r_oz;
    assign o_cell_x      = r_cx;
    assign o_cell_y      = r_cy;
    assign o_cell_z      = r_cz;
    assign o_copy_kind   = r_okind;
    assign o_cell_count  = r_ocnt;
    assign o_total_count = r_otot;
    assign o_last_copy   = r_olast;

endmodule
